>>> design/barometer_compensation_unit_macros.svh
// assertion helpers for the barometer compensation unit
`ifndef BAROMETER_COMPENSATION_UNIT_MACROS_SVH
`define BAROMETER_COMPENSATION_UNIT_MACROS_SVH

// same-cycle implication under an active-low reset
`define BCU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under an active-low reset
`define BCU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/bcu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bcu_pkg;

    // configuration register indexes
    localparam logic [7:0] REG_TEMP_COEFFS = 8'd0;
    localparam logic [7:0] REG_PRESS_LOW   = 8'd1;
    localparam logic [7:0] REG_PRESS_HIGH  = 8'd2;
    localparam logic [7:0] REG_PRESS_NINE  = 8'd3;

    // quotient bits resolved one per divider stage
    localparam int DIV_STEPS = 64;
    localparam int DEN_W     = 31;

    // sideband that rides along the divider
    typedef struct packed {
        logic signed [15:0] temp;
        logic               neg;
        logic               dz;
    } t_side;

endpackage

`default_nettype wire

>>> design/bcu_mul64.sv
`timescale 1ns / 1ps
`default_nettype none

// low 64 bits of a 64x64 product, two register stages
module bcu_mul64 (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic      [63:0] o_p
);

    logic [63:0] r_ll;
    logic [31:0] r_lh;
    logic [31:0] r_hl;
    logic [63:0] r_p;

    // partial products, high by high drops out of the low word
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[31:0] * i_b[31:0];
            r_lh <= i_a[31:0] * i_b[63:32];
            r_hl <= i_a[63:32] * i_b[31:0];
            r_p  <= r_ll + {r_lh + r_hl, 32'd0};
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

>>> design/bcu_div.sv
`timescale 1ns / 1ps
`default_nettype none

// unsigned restoring divider, one quotient bit per stage
module bcu_div
    import bcu_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [63:0]      i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire t_side            i_side,
    output logic      [63:0]      o_quot,
    output t_side                 o_side
);

    logic [DEN_W-1:0] r_rem  [DIV_STEPS];
    logic [63:0]      r_work [DIV_STEPS];
    logic [DEN_W-1:0] r_den  [DIV_STEPS];
    t_side            r_side [DIV_STEPS];

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [63:0]      work_in;
        logic [DEN_W-1:0] den_in;
        t_side            side_in;
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] n_rem;

        // previous stage or the input
        if (g == 0) begin : g_first
            assign rem_in  = '0;
            assign work_in = i_num;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign work_in = r_work[g-1];
            assign den_in  = r_den[g-1];
            assign side_in = r_side[g-1];
        end

        // trial subtract
        always_comb begin
            trial = {rem_in, work_in[63]};
            ge    = (trial >= {1'b0, den_in});
            if (ge) begin
                n_rem = DEN_W'(trial - {1'b0, den_in});
            end else begin
                n_rem = trial[DEN_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_work[g] <= {work_in[62:0], ge};
                r_den[g]  <= den_in;
                r_side[g] <= side_in;
            end
        end
    end

    assign o_quot = r_work[DIV_STEPS-1];
    assign o_side = r_side[DIV_STEPS-1];

endmodule

`default_nettype wire

>>> design/barometer_compensation_unit.sv
// throughput: one sample pair per cycle while the skid register is empty, set by
// the 64-stage divider pipeline and the two-stage 64-bit multipliers, which all
// take a new operand each cycle
// a stalled output parks one beat in a skid register before input stalls
// reset (synchronous, active low) clears valid bits and the calibration words
`timescale 1ns / 1ps
`default_nettype none
`include "barometer_compensation_unit_macros.svh"

module barometer_compensation_unit
    import bcu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    // sample input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // raw_pressure[19:0], raw_temperature[39:20]
    // result output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,  // temperature_centi[15:0], pressure_q24_8[47:16]
    output logic [0:0]       m_tuser   // valid_res[0]
);

    localparam int ST_Q    = DIV_STEPS + 15;
    localparam int ST_LAST = ST_Q + 6;

    typedef struct packed {
        logic signed [15:0] temp;
        logic [31:0]        press;
        logic               ok;
    } t_res;

    // calibration words
    logic [47:0] r_tc;
    logic [63:0] r_pcl;
    logic [63:0] r_pch;
    logic [15:0] r_p9;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc  <= '0;
            r_pcl <= '0;
            r_pch <= '0;
            r_p9  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TEMP_COEFFS: r_tc  <= i_cfg_data[47:0];
                REG_PRESS_LOW:   r_pcl <= i_cfg_data;
                REG_PRESS_HIGH:  r_pch <= i_cfg_data;
                REG_PRESS_NINE:  r_p9  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    logic [15:0]        t1;
    logic signed [15:0] t2, t3;
    logic [15:0]        p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = r_tc[15:0];
    assign t2 = $signed(r_tc[31:16]);
    assign t3 = $signed(r_tc[47:32]);
    assign p1 = r_pcl[15:0];
    assign p2 = $signed(r_pcl[31:16]);
    assign p3 = $signed(r_pcl[47:32]);
    assign p4 = $signed(r_pcl[63:48]);
    assign p5 = $signed(r_pch[15:0]);
    assign p6 = $signed(r_pch[31:16]);
    assign p7 = $signed(r_pch[47:32]);
    assign p8 = $signed(r_pch[63:48]);
    assign p9 = $signed(r_p9);

    // pipeline advance, held while the skid register is full
    logic           en;
    logic           r_k_vld;
    logic [ST_LAST:0] r_vld;

    assign en       = !r_k_vld;
    assign s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[ST_LAST-1:0], s_tvalid};
        end
    end

    // temperature stages
    logic [19:0]        r0_p, r0_t;
    logic signed [17:0] r1_a;
    logic signed [16:0] r1_b;
    logic signed [33:0] r2_m1, r2_bb;
    logic signed [22:0] r3_v1, r4_v1;
    logic [19:0]        r3_bbs;
    logic signed [36:0] r4_m3;
    logic signed [23:0] r5_tf;
    logic signed [24:0] r6_v1;
    logic [20:0]        r_pd [1:10];
    logic signed [15:0] r_tl [6:14];

    logic signed [27:0] n6_t5;
    logic signed [19:0] n6_t20;
    logic signed [15:0] n6_temp;

    // scaled temperature with saturation
    always_comb begin
        n6_t5  = 28'(r5_tf) * 28'sd5 + 28'sd128;
        n6_t20 = 20'(n6_t5 >>> 8);
        if (n6_t20 > 20'sd32767) begin
            n6_temp = 16'sh7fff;
        end else if (n6_t20 < -20'sd32768) begin
            n6_temp = 16'sh8000;
        end else begin
            n6_temp = n6_t20[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_p   <= s_tdata[19:0];
            r0_t   <= s_tdata[39:20];
            r1_a   <= $signed({1'b0, r0_t[19:3]}) - $signed({1'b0, t1, 1'b0});
            r1_b   <= $signed({1'b0, r0_t[19:4]}) - $signed({1'b0, t1});
            r_pd[1] <= 21'd1048576 - {1'b0, r0_p};
            r2_m1  <= r1_a * t2;
            r2_bb  <= r1_b * r1_b;
            r3_v1  <= 23'(r2_m1 >>> 11);
            r3_bbs <= r2_bb[31:12];
            r4_m3  <= $signed({1'b0, r3_bbs}) * t3;
            r4_v1  <= r3_v1;
            r5_tf  <= 24'(r4_v1) + 24'(r4_m3 >>> 14);
            r6_v1  <= 25'(r5_tf) - 25'sd128000;
            r_tl[6] <= n6_temp;
            for (int k = 2; k <= 10; k++) begin
                r_pd[k] <= r_pd[k-1];
            end
            for (int k = 7; k <= 14; k++) begin
                r_tl[k] <= r_tl[k-1];
            end
        end
    end

    // pressure polynomial
    logic signed [49:0] r7_sq;
    logic signed [40:0] r_m5 [7:9];
    logic signed [40:0] r_m2 [7:9];
    logic [63:0]        w_sq6, w_sq3;
    logic [63:0]        r10_v2, r10_v1;
    logic [63:0]        r11_x, r11_e;
    logic [63:0]        w_n, w_pe;

    bcu_mul64 u_mul_p6 (
        .i_clk (i_clk), .i_en (en),
        .i_a (64'(r7_sq)), .i_b (64'(p6)), .o_p (w_sq6)
    );

    bcu_mul64 u_mul_p3 (
        .i_clk (i_clk), .i_en (en),
        .i_a (64'(r7_sq)), .i_b (64'(p3)), .o_p (w_sq3)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_sq   <= r6_v1 * r6_v1;
            r_m5[7] <= r6_v1 * p5;
            r_m2[7] <= r6_v1 * p2;
            for (int k = 8; k <= 9; k++) begin
                r_m5[k] <= r_m5[k-1];
                r_m2[k] <= r_m2[k-1];
            end
            r10_v2 <= w_sq6 + (64'(r_m5[9]) << 17) + (64'(p4) << 35);
            r10_v1 <= 64'($signed(w_sq3) >>> 8) + (64'(r_m2[9]) << 12);
            r11_x  <= ({43'd0, r_pd[10]} << 31) - r10_v2;
            r11_e  <= 64'h0000_8000_0000_0000 + r10_v1;
        end
    end

    bcu_mul64 u_mul_scale (
        .i_clk (i_clk), .i_en (en),
        .i_a (r11_x), .i_b (64'd3125), .o_p (w_n)
    );

    bcu_mul64 u_mul_p1 (
        .i_clk (i_clk), .i_en (en),
        .i_a (r11_e), .i_b ({48'd0, p1}), .o_p (w_pe)
    );

    // magnitudes and sign for the divider
    logic [DEN_W-1:0] w_d;
    logic [63:0]      r14_nmag;
    logic [DEN_W-1:0] r14_dmag;
    t_side            r14_side;

    assign w_d = w_pe[63:33];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r14_nmag      <= w_n[63] ? (64'd0 - w_n) : w_n;
            r14_dmag      <= w_d[DEN_W-1] ? DEN_W'(31'd0 - w_d) : w_d;
            r14_side.temp <= r_tl[13];
            r14_side.neg  <= w_n[63] ^ w_d[DEN_W-1];
            r14_side.dz   <= (w_d == '0);
        end
    end

    logic [63:0] w_quot;
    t_side       w_side;

    bcu_div u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r14_nmag),
        .i_den  (r14_dmag),
        .i_side (r14_side),
        .o_quot (w_quot),
        .o_side (w_side)
    );

    // second-order pressure terms
    logic [63:0] r_q    [ST_Q:ST_Q+4];
    t_side       r_side_l [ST_Q:ST_Q+5];
    logic [63:0] r_a    [ST_Q+1:ST_Q+2];
    logic [63:0] r_v2   [ST_Q+3:ST_Q+4];
    logic [63:0] w_a, w_m8, w_m9, w_m9a;
    logic [63:0] r_s;
    logic [63:0] w_p;
    t_res        n_res, r_res;

    assign w_a = 64'($signed(r_q[ST_Q]) >>> 13);

    bcu_mul64 u_mul_p8 (
        .i_clk (i_clk), .i_en (en),
        .i_a (r_q[ST_Q]), .i_b (64'(p8)), .o_p (w_m8)
    );

    bcu_mul64 u_mul_p9 (
        .i_clk (i_clk), .i_en (en),
        .i_a (w_a), .i_b (64'(p9)), .o_p (w_m9)
    );

    bcu_mul64 u_mul_sq (
        .i_clk (i_clk), .i_en (en),
        .i_a (w_m9), .i_b (r_a[ST_Q+2]), .o_p (w_m9a)
    );

    // final offset, sign test and saturation
    always_comb begin
        w_p         = 64'($signed(r_s) >>> 8) + (64'(p7) << 4);
        n_res.temp  = r_side_l[ST_Q+5].temp;
        n_res.ok    = !r_side_l[ST_Q+5].dz && !w_p[63] && (w_p != 64'd0);
        if (!n_res.ok) begin
            n_res.press = 32'd0;
        end else if (w_p[63:32] != 32'd0) begin
            n_res.press = 32'hffff_ffff;
        end else begin
            n_res.press = w_p[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q[ST_Q]      <= w_side.neg ? (64'd0 - w_quot) : w_quot;
            r_side_l[ST_Q] <= w_side;
            for (int k = ST_Q + 1; k <= ST_Q + 4; k++) begin
                r_q[k] <= r_q[k-1];
            end
            for (int k = ST_Q + 1; k <= ST_Q + 5; k++) begin
                r_side_l[k] <= r_side_l[k-1];
            end
            r_a[ST_Q+1]  <= w_a;
            r_a[ST_Q+2]  <= r_a[ST_Q+1];
            r_v2[ST_Q+3] <= 64'($signed(w_m8) >>> 19);
            r_v2[ST_Q+4] <= r_v2[ST_Q+3];
            r_s          <= r_q[ST_Q+4] + r_v2[ST_Q+4] + 64'($signed(w_m9a) >>> 25);
            r_res        <= n_res;
        end
    end

    // output register with skid beat
    logic r_o_vld;
    t_res r_o, r_k;
    logic inc, pop;

    assign inc = r_vld[ST_LAST] && en;
    assign pop = r_o_vld && m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
            r_k_vld <= 1'b0;
        end else if (pop || !r_o_vld) begin
            r_o_vld <= r_k_vld || inc;
            r_k_vld <= 1'b0;
        end else if (inc) begin
            r_k_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop || !r_o_vld) begin
            r_o <= r_k_vld ? r_k : r_res;
        end else if (inc) begin
            r_k <= r_res;
        end
    end

    assign m_tvalid = r_o_vld;
    assign m_tdata  = {r_o.press, r_o.temp};
    assign m_tuser  = r_o.ok;

    // checks
    `BCU_ASSERT_IMPL(a_skid_needs_out, i_clk, i_rst_n, r_k_vld, r_o_vld, "skid beat without output beat")
    `BCU_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, s_tvalid && s_tready, r_vld[0], "accepted beat lost at entry")
    `BCU_ASSERT_IMPL(a_bad_press_zero, i_clk, i_rst_n, m_tvalid && !m_tuser[0], m_tdata[47:16] == 32'd0, "invalid result with nonzero pressure")

endmodule

`default_nettype wire

>>> verif/tb_barometer_compensation_unit.sv
`timescale 1ns / 1ps

module tb_barometer_compensation_unit;
    import bcu_pkg::*;

    localparam int         LATENCY      = 86;
    localparam int         IDLE_LIMIT   = 4000;
    localparam logic [7:0] REG_UNUSED   = 8'hFF;
    localparam logic [7:0] REG_PAST_END = 8'd4;

    // typical factory calibration words
    localparam logic [15:0] TYP_T1 = 16'd27504;
    localparam logic [15:0] TYP_T2 = 16'd26435;
    localparam logic [15:0] TYP_T3 = -16'sd1000;
    localparam logic [15:0] TYP_P1 = 16'd36477;
    localparam logic [15:0] TYP_P2 = -16'sd10685;
    localparam logic [15:0] TYP_P3 = 16'd3024;
    localparam logic [15:0] TYP_P4 = 16'd2855;
    localparam logic [15:0] TYP_P5 = 16'd140;
    localparam logic [15:0] TYP_P6 = -16'sd7;
    localparam logic [15:0] TYP_P7 = 16'd15500;
    localparam logic [15:0] TYP_P8 = -16'sd14600;
    localparam logic [15:0] TYP_P9 = 16'd6000;

    typedef struct packed {
        logic signed [15:0] temp_centi;
        logic [31:0]        press_q24_8;
        logic               press_ok;
    } t_reading;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;

    // calibration copy held by the predictor
    logic [47:0] cal_temp;
    logic [63:0] cal_press_low;
    logic [63:0] cal_press_high;
    logic [15:0] cal_nine;

    t_reading readings_due[$];
    int       n_errors;
    int       idle_cycles;
    int       burst_left;

    barometer_compensation_unit dut (.*);

    always #10 i_clk = ~i_clk;

    // signed division truncating toward zero, most negative by -1 wraps
    function automatic logic signed [63:0] div_trunc(logic signed [63:0] num,
                                                     logic signed [63:0] den);
        logic [63:0] mag_n;
        logic [63:0] mag_d;
        logic [63:0] quo;
        mag_n = num[63] ? -num : num;
        mag_d = den[63] ? -den : den;
        quo   = mag_n / mag_d;
        return (num[63] != den[63]) ? -quo : quo;
    endfunction

    function automatic logic signed [63:0] sx16(logic [15:0] w);
        return {{48{w[15]}}, w};
    endfunction

    // integer compensation of one sample pair
    function automatic t_reading compensate(logic [19:0] raw_p, logic [19:0] raw_t);
        logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] adc_p, adc_t, x, y, fine, tc, u1, u2, pr;
        t_reading r;
        t1 = {48'd0, cal_temp[15:0]};
        t2 = sx16(cal_temp[31:16]);
        t3 = sx16(cal_temp[47:32]);
        p1 = {48'd0, cal_press_low[15:0]};
        p2 = sx16(cal_press_low[31:16]);
        p3 = sx16(cal_press_low[47:32]);
        p4 = sx16(cal_press_low[63:48]);
        p5 = sx16(cal_press_high[15:0]);
        p6 = sx16(cal_press_high[31:16]);
        p7 = sx16(cal_press_high[47:32]);
        p8 = sx16(cal_press_high[63:48]);
        p9 = sx16(cal_nine);
        adc_p = {44'd0, raw_p};
        adc_t = {44'd0, raw_t};
        r = '0;

        // temperature and fine value
        x    = (adc_t >>> 3) - (t1 <<< 1);
        u1   = (x * t2) >>> 11;
        y    = (adc_t >>> 4) - t1;
        u2   = (((y * y) >>> 12) * t3) >>> 14;
        fine = u1 + u2;
        tc   = (fine * 64'sd5 + 64'sd128) >>> 8;
        if (tc > 64'sd32767)
            tc = 64'sd32767;
        else if (tc < -64'sd32768)
            tc = -64'sd32768;
        r.temp_centi = tc[15:0];

        // pressure polynomial and divisor
        u1 = fine - 64'sd128000;
        u2 = u1 * u1 * p6;
        u2 = u2 + ((u1 * p5) <<< 17);
        u2 = u2 + (p4 <<< 35);
        u1 = ((u1 * u1 * p3) >>> 8) + ((u1 * p2) <<< 12);
        u1 = (((64'sd1 <<< 47) + u1) * p1) >>> 33;
        if (u1 != 0) begin
            pr = 64'sd1048576 - adc_p;
            pr = div_trunc(((pr <<< 31) - u2) * 64'sd3125, u1);
            x  = pr >>> 13;
            u2 = (p8 * pr) >>> 19;
            u1 = (p9 * x * x) >>> 25;
            pr = ((pr + u1 + u2) >>> 8) + (p7 <<< 4);
            if (pr > 0) begin
                r.press_q24_8 = (pr > 64'sd4294967295) ? 32'hFFFF_FFFF : pr[31:0];
                r.press_ok    = 1'b1;
            end
        end
        return r;
    endfunction

    // receiver stall pattern: free running, coin flips, or long stalls
    int stall_mode = 0;
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 97 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= (stall_phase % 24) < 6;
        endcase
    end

    // result checker
    always @(posedge i_clk) begin
        t_reading got;
        t_reading want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = {m_tdata[15:0], m_tdata[47:16], m_tuser[0]};
            if (readings_due.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, got);
                n_errors++;
            end else begin
                want = readings_due.pop_front();
                if (got.temp_centi !== want.temp_centi) begin
                    $display("%0t: temperature expected %0d actual %0d", $time,
                             want.temp_centi, got.temp_centi);
                    n_errors++;
                end
                if (got.press_q24_8 !== want.press_q24_8) begin
                    $display("%0t: pressure expected %h actual %h", $time,
                             want.press_q24_8, got.press_q24_8);
                    n_errors++;
                end
                if (got.press_ok !== want.press_ok) begin
                    $display("%0t: valid expected %b actual %b", $time,
                             want.press_ok, got.press_ok);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one sample beat, with bursts and gaps on the sender side
    task automatic send_sample(logic [19:0] raw_p, logic [19:0] raw_t);
        s_tvalid <= 1'b1;
        s_tdata  <= {raw_t, raw_p};
        do @(posedge i_clk); while (!s_tready);
        readings_due.push_back(compensate(raw_p, raw_t));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(50, 150)
                                                   : $urandom_range(0, 12);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    // wait for the pipeline to drain before touching calibration
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (readings_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_cal(logic [7:0] idx, logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_TEMP_COEFFS: cal_temp = val[47:0];
            REG_PRESS_LOW:   cal_press_low = val;
            REG_PRESS_HIGH:  cal_press_high = val;
            REG_PRESS_NINE:  cal_nine = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic load_cal(logic [63:0] tc, logic [63:0] pl, logic [63:0] ph,
                            logic [63:0] p9);
        drain();
        write_cal(REG_TEMP_COEFFS, tc);
        write_cal(REG_PRESS_LOW, pl);
        write_cal(REG_PRESS_HIGH, ph);
        write_cal(REG_PRESS_NINE, p9);
    endtask

    task automatic load_typical();
        load_cal({16'hDEAD, TYP_T3, TYP_T2, TYP_T1}, {TYP_P4, TYP_P3, TYP_P2, TYP_P1},
                 {TYP_P8, TYP_P7, TYP_P6, TYP_P5}, {48'hBEEF_0000_0000, TYP_P9});
    endtask

    // calibration at reset is all zero, so the divisor is zero
    task automatic test_zero_divisor();
        send_sample(20'd0, 20'd0);
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'd415148, 20'd519888);
    endtask

    // field extremes under typical calibration, plus two ignored register indexes
    task automatic test_field_extremes();
        load_typical();
        send_sample(20'd415148, 20'd519888);
        send_sample(20'd0, 20'd519888);
        send_sample(20'hFFFFF, 20'd519888);
        send_sample(20'd415148, 20'd0);
        send_sample(20'd415148, 20'hFFFFF);
        send_sample(20'd0, 20'd0);
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'h55555, 20'hAAAAA);
        drain();
        write_cal(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cal(REG_PAST_END, 64'h0);
        send_sample(20'd415148, 20'd519888);
    endtask

    // extreme calibration: saturating temperature, huge and negative pressure
    task automatic test_extreme_cal();
        load_cal(64'hFFFF_7FFF_7FFF_0000, 64'h7FFF_7FFF_7FFF_FFFF,
                 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF);
        send_sample(20'd0, 20'hFFFFF);
        send_sample(20'hFFFFF, 20'd0);
        send_sample(20'd1000, 20'd500000);
        load_cal(64'h0000_8000_8000_FFFF, 64'h8000_8000_8000_0001,
                 64'h8000_8000_8000_8000, 64'hFFFF_FFFF_FFFF_8000);
        send_sample(20'd0, 20'hFFFFF);
        send_sample(20'hFFFFF, 20'd0);
        send_sample(20'd700000, 20'd100);
        // large positive pressure offset via p7
        load_cal({16'd0, TYP_T3, TYP_T2, TYP_T1}, {TYP_P4, TYP_P3, TYP_P2, TYP_P1},
                 {TYP_P8, 16'h7FFF, TYP_P6, TYP_P5}, 64'h0);
        send_sample(20'd0, 20'd519888);
        send_sample(20'hFFFFF, 20'd519888);
    endtask

    function automatic logic [15:0] nudge(logic [15:0] w);
        return w + 16'($signed($urandom_range(0, 400)) - 200);
    endfunction

    // random samples across a series of calibration sets
    task automatic test_random_samples();
        logic [19:0] rp;
        logic [19:0] rt;
        for (int set = 0; set < 12; set++) begin
            if ($urandom_range(0, 3) != 0)
                load_cal({16'($urandom()), nudge(TYP_T3), nudge(TYP_T2), nudge(TYP_T1)},
                         {nudge(TYP_P4), nudge(TYP_P3), nudge(TYP_P2), nudge(TYP_P1)},
                         {nudge(TYP_P8), nudge(TYP_P7), nudge(TYP_P6), nudge(TYP_P5)},
                         {$urandom(), 16'($urandom()), nudge(TYP_P9)});
            else
                load_cal({$urandom(), $urandom()}, {$urandom(), $urandom()},
                         {$urandom(), $urandom()}, {$urandom(), $urandom()});
            for (int k = 0; k < 115; k++) begin
                if ($urandom_range(0, 9) < 7) begin
                    rp = 20'($urandom_range(250000, 600000));
                    rt = 20'($urandom_range(400000, 650000));
                end else begin
                    rp = 20'($urandom());
                    rt = 20'($urandom());
                end
                send_sample(rp, rt);
            end
        end
    endtask

    initial begin
        n_errors    = 0;
        idle_cycles = 0;
        burst_left  = 0;
        cal_temp       = '0;
        cal_press_low  = '0;
        cal_press_high = '0;
        cal_nine       = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_divisor();
        test_field_extremes();
        test_extreme_cal();
        test_random_samples();

        s_tvalid <= 1'b0;
        while (readings_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/bcu_pkg.sv
design/bcu_mul64.sv
design/bcu_div.sv
design/barometer_compensation_unit.sv
verif/tb_barometer_compensation_unit.sv
